// File: hw/rtl/rsc_pkg.sv
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ERR_W   = 2;
  localparam int unsigned DEPTH_W = 6;

  // Token codes carried on the input channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 3'd0,
    KIND_ADD   = 3'd1,
    KIND_SUB   = 3'd2,
    KIND_MUL   = 3'd3,
    KIND_DIV   = 3'd4,
    KIND_PRINT = 3'd5
  } kind_e;

  // Error codes reported with every result word.
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE         = 2'd0,
    ERR_INSUFFICIENT = 2'd1,
    ERR_OVERFLOW     = 2'd2,
    ERR_DIVZERO      = 2'd3
  } err_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load_token;
    logic  push_num;
    logic  push_res;
    logic  pop;
    logic  take_b;
    logic  take_a;
    logic  set_err;
    err_e  err;
    logic  set_shown;
    logic  div_start;
    logic  out_load;
  } dp_cmd_t;

  // Status from the datapath and the divider back to the controller.
  typedef struct packed {
    kind_e kind;
    logic  empty;
    logic  full;
    logic  b_zero;
    logic  div_done;
    logic  out_room;
  } dp_sts_t;

endpackage

// File: hw/rtl/rsc_if.sv
`timescale 1ns / 1ps

interface rsc_in_if;
  logic                                valid;
  logic                                ready;
  logic [rsc_pkg::KIND_W-1:0]          kind;
  logic signed [rsc_pkg::WORD_W-1:0]   number;

  modport source (output valid, output kind, output number, input ready);
  modport sink   (input valid, input kind, input number, output ready);
endinterface

interface rsc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                shown;
  logic signed [rsc_pkg::WORD_W-1:0]   shown_value;
  logic [rsc_pkg::ERR_W-1:0]           error;
  logic [rsc_pkg::DEPTH_W-1:0]         depth;

  modport source (output valid, output shown, output shown_value, output error,
                  output depth, input ready);
  modport sink   (input valid, input shown, input shown_value, input error,
                  input depth, output ready);
endinterface

// File: hw/rtl/rpn_stack_calculator_core.sv
// Steps: a push or an ignored token is decoded and goes straight to the result word;
// print also pops the top, add/subtract/multiply pop B and A and operate, divide also
// waits for the divider. Throughput: one token at a time; the next is taken once the
// previous result word is registered, which waits for room on the output.
// Reset: rst_ni is asynchronous, active low; it empties the stack and drops valid.
// Stack contents are not cleared; only entries below the word count are ever read.
`timescale 1ns / 1ps

module rpn_stack_calculator_core #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rsc_in_if.sink        tok_i,
  rsc_out_if.source     res_o
);

  // The controller steps each token through a short sequence: latch, decode,
  // pop B, pop A, operate, then load the result register. The stack lives in a
  // single-port memory with a registered read, so each popped word is registered
  // before it can be used.
  rsc_pkg::dp_cmd_t cmd;
  rsc_pkg::dp_sts_t dp_sts;
  rsc_pkg::dp_sts_t ctrl_sts;

  logic [rsc_pkg::WORD_W-1:0] opa;
  logic [rsc_pkg::WORD_W-1:0] opb;
  logic [rsc_pkg::WORD_W-1:0] div_quo;
  logic                       div_done;
  logic [rsc_pkg::WORD_W-1:0] shown_value;

  // The divider's done pulse joins the datapath status on its way to the
  // controller.
  always_comb begin
    ctrl_sts          = dp_sts;
    ctrl_sts.div_done = div_done;
  end

  rsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_i.valid),
    .tok_ready_o (tok_i.ready),
    .sts_i       (ctrl_sts),
    .cmd_o       (cmd)
  );

  rsc_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (dp_sts),
    .tok_kind_i        (tok_i.kind),
    .tok_number_i      (tok_i.number),
    .opa_o             (opa),
    .opb_o             (opb),
    .div_quo_i         (div_quo),
    .res_valid_o       (res_o.valid),
    .res_ready_i       (res_o.ready),
    .res_shown_o       (res_o.shown),
    .res_shown_value_o (shown_value),
    .res_error_o       (res_o.error),
    .res_depth_o       (res_o.depth)
  );

  // A division starts only after both operands are held and the divisor has
  // been checked for zero.
  rsc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd.div_start),
    .dividend_i (opa),
    .divisor_i  (opb),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign res_o.shown_value = signed'(shown_value);

endmodule

// File: hw/rtl/rsc_divider.sv
`timescale 1ns / 1ps

// Signed restoring divider, one quotient bit per cycle. The quotient
// truncates toward zero; the most negative word divided by minus one wraps.
module rsc_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [rsc_pkg::WORD_W-1:0]         dividend_i,
  input  logic [rsc_pkg::WORD_W-1:0]         divisor_i,
  output logic                               done_o,
  output logic [rsc_pkg::WORD_W-1:0]         quotient_o
);

  localparam int unsigned W    = rsc_pkg::WORD_W;
  localparam int unsigned CNTW = $clog2(W);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic            neg_q, neg_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [W:0]      shifted;
  logic [W+1:0]    diff;
  logic            fits;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~diff[W+1];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[W-1] ? (~dividend_i + W'(1)) : dividend_i;
      dvs_d  = divisor_i[W-1] ? (~divisor_i + W'(1)) : divisor_i;
      neg_d  = dividend_i[W-1] ^ divisor_i[W-1];
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + W'(1)) : quo_q;

endmodule

// File: hw/rtl/rsc_datapath.sv
`timescale 1ns / 1ps

// Stack memory, word count, operand registers, adder and multiplier,
// and the result word register.
module rsc_datapath #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rsc_pkg::dp_cmd_t                   cmd_i,
  output rsc_pkg::dp_sts_t                   sts_o,
  input  logic [rsc_pkg::KIND_W-1:0]         tok_kind_i,
  input  logic [rsc_pkg::WORD_W-1:0]         tok_number_i,
  output logic [rsc_pkg::WORD_W-1:0]         opa_o,
  output logic [rsc_pkg::WORD_W-1:0]         opb_o,
  input  logic [rsc_pkg::WORD_W-1:0]         div_quo_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic                               res_shown_o,
  output logic [rsc_pkg::WORD_W-1:0]         res_shown_value_o,
  output logic [rsc_pkg::ERR_W-1:0]          res_error_o,
  output logic [rsc_pkg::DEPTH_W-1:0]        res_depth_o
);

  localparam int unsigned W  = rsc_pkg::WORD_W;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [W-1:0]        mem [STACK_DEPTH];
  logic [W-1:0]        rd_data_q;
  logic [CW-1:0]       count_q, count_d;
  rsc_pkg::kind_e      kind_q;
  logic [W-1:0]        number_q;
  logic [W-1:0]        a_q, b_q;
  rsc_pkg::err_e       err_q, err_d;
  logic                shown_q, shown_d;
  logic                res_valid_q, res_valid_d;
  logic                res_shown_q;
  logic [W-1:0]        res_value_q;
  rsc_pkg::err_e       res_err_q;
  logic [rsc_pkg::DEPTH_W-1:0] res_depth_q;
  logic                wr_en;
  logic [W-1:0]        wr_data;
  logic [W-1:0]        alu_res;
  logic [AW-1:0]       top_addr;

  assign top_addr = AW'(count_q - CW'(1));
  assign wr_en    = cmd_i.push_num | cmd_i.push_res;
  assign wr_data  = cmd_i.push_num ? number_q : alu_res;

  always_comb begin
    case (kind_q)
      rsc_pkg::KIND_ADD: alu_res = a_q + b_q;
      rsc_pkg::KIND_SUB: alu_res = a_q - b_q;
      rsc_pkg::KIND_MUL: alu_res = a_q * b_q;
      rsc_pkg::KIND_DIV: alu_res = div_quo_i;
      default:           alu_res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AW'(count_q)] <= wr_data;
    end
    if (cmd_i.pop) begin
      rd_data_q <= mem[top_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (wr_en) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end

    err_d   = err_q;
    shown_d = shown_q;
    if (cmd_i.load_token) begin
      err_d   = rsc_pkg::ERR_NONE;
      shown_d = 1'b0;
    end else begin
      if (cmd_i.set_err) begin
        err_d = cmd_i.err;
      end
      if (cmd_i.set_shown) begin
        shown_d = 1'b1;
      end
    end

    res_valid_d = res_valid_q;
    if (cmd_i.out_load) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= rsc_pkg::ERR_NONE;
      shown_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      err_q       <= err_d;
      shown_q     <= shown_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_token) begin
      kind_q   <= rsc_pkg::kind_e'(tok_kind_i);
      number_q <= tok_number_i;
    end
    if (cmd_i.take_b) begin
      b_q <= rd_data_q;
    end
    if (cmd_i.take_a) begin
      a_q <= rd_data_q;
    end
    if (cmd_i.out_load) begin
      res_shown_q <= shown_q;
      res_value_q <= shown_q ? a_q : '0;
      res_err_q   <= err_q;
      res_depth_q <= rsc_pkg::DEPTH_W'(count_q);
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CW'(STACK_DEPTH));
  assign sts_o.b_zero   = (b_q == '0);
  assign sts_o.div_done = 1'b0;
  assign sts_o.out_room = ~res_valid_q | res_ready_i;

  assign opa_o             = a_q;
  assign opb_o             = b_q;
  assign res_valid_o       = res_valid_q;
  assign res_shown_o       = res_shown_q;
  assign res_shown_value_o = res_value_q;
  assign res_error_o       = res_err_q;
  assign res_depth_o       = res_depth_q;

endmodule

// File: hw/rtl/rsc_ctrl.sv
`timescale 1ns / 1ps

// Token sequencer: decodes the latched token and steps the datapath
// through pops, the operation and the result word.
module rsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  output logic              tok_ready_o,
  input  rsc_pkg::dp_sts_t  sts_i,
  output rsc_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DECODE   = 7'b0000010,
    ST_GET_B    = 7'b0000100,
    ST_GET_A    = 7'b0001000,
    ST_EXEC     = 7'b0010000,
    ST_DIV_WAIT = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  assign tok_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (tok_valid_i) begin
          cmd_o.load_token = 1'b1;
          state_d          = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FINISH;
        unique case (sts_i.kind) inside
          rsc_pkg::KIND_PUSH: begin
            if (sts_i.full) begin
              cmd_o.set_err = 1'b1;
              cmd_o.err     = rsc_pkg::ERR_OVERFLOW;
            end else begin
              cmd_o.push_num = 1'b1;
            end
          end
          rsc_pkg::KIND_PRINT: begin
            if (sts_i.empty) begin
              cmd_o.set_err = 1'b1;
              cmd_o.err     = rsc_pkg::ERR_INSUFFICIENT;
            end else begin
              cmd_o.pop = 1'b1;
              state_d   = ST_GET_A;
            end
          end
          rsc_pkg::KIND_ADD, rsc_pkg::KIND_SUB, rsc_pkg::KIND_MUL,
          rsc_pkg::KIND_DIV: begin
            if (sts_i.empty) begin
              cmd_o.set_err = 1'b1;
              cmd_o.err     = rsc_pkg::ERR_INSUFFICIENT;
            end else begin
              cmd_o.pop = 1'b1;
              state_d   = ST_GET_B;
            end
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_GET_B: begin
        cmd_o.take_b = 1'b1;
        if (sts_i.empty) begin
          cmd_o.set_err = 1'b1;
          cmd_o.err     = rsc_pkg::ERR_INSUFFICIENT;
          state_d       = ST_FINISH;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_GET_A;
        end
      end
      ST_GET_A: begin
        cmd_o.take_a = 1'b1;
        if (sts_i.kind == rsc_pkg::KIND_PRINT) begin
          cmd_o.set_shown = 1'b1;
          state_d         = ST_FINISH;
        end else begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.kind == rsc_pkg::KIND_DIV) begin
          if (sts_i.b_zero) begin
            cmd_o.set_err = 1'b1;
            cmd_o.err     = rsc_pkg::ERR_DIVZERO;
            state_d       = ST_FINISH;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV_WAIT;
          end
        end else begin
          cmd_o.push_res = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.push_res = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_room) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/rsc_checker.sv
`timescale 1ns / 1ps

module rsc_checker #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               tok_valid_i,
  input logic                               tok_ready_i,
  input logic                               res_valid_i,
  input logic                               res_ready_i,
  input logic                               res_shown_i,
  input logic [rsc_pkg::WORD_W-1:0]         res_shown_value_i,
  input logic [rsc_pkg::ERR_W-1:0]          res_error_i,
  input logic [rsc_pkg::DEPTH_W-1:0]        res_depth_i
);

  // One token at a time: acceptance closes the input until the token is done.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_ready_i |=> !tok_ready_i)
    else $error("token accepted while another was in progress");

  a_shown_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_shown_i |-> res_error_i == rsc_pkg::ERR_NONE)
    else $error("printed word carries an error code");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_shown_i |-> res_shown_value_i == '0)
    else $error("value shown without a print");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (STACK_DEPTH > 63) || (res_depth_i <= rsc_pkg::DEPTH_W'(STACK_DEPTH)))
    else $error("reported depth beyond stack size");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_shown_value_i)
      && $stable(res_depth_i) && $stable(res_error_i))
    else $error("stalled result word changed");

endmodule

bind rpn_stack_calculator_core rsc_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_rsc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .tok_valid_i       (tok_i.valid),
  .tok_ready_i       (tok_i.ready),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .res_shown_i       (res_o.shown),
  .res_shown_value_i (res_o.shown_value),
  .res_error_i       (res_o.error),
  .res_depth_i       (res_o.depth)
);

// File: tb/sv/rpn_stack_calculator_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the calculator stack and checks
// every result word against the oldest outstanding prediction.
module rpn_stack_calculator_checker #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsc_in_if           tok_i,
  rsc_out_if          res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned shown_count_o,
  output int unsigned underflow_count_o,
  output int unsigned overflow_count_o,
  output int unsigned divzero_count_o
);

  typedef struct packed {
    logic                         shown;
    logic [rsc_pkg::WORD_W-1:0]   shown_value;
    rsc_pkg::err_e                error;
    logic [rsc_pkg::DEPTH_W-1:0]  depth;
  } calc_result_t;

  logic [rsc_pkg::WORD_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned                stack_level;
  calc_result_t               result_q [$];

  // Applies one token to the shadow stack and returns the result word it gives.
  function automatic calc_result_t eval_token(input logic [rsc_pkg::KIND_W-1:0] kind,
                                              input logic [rsc_pkg::WORD_W-1:0] number);
    calc_result_t               r;
    logic [rsc_pkg::WORD_W-1:0] op_a;
    logic [rsc_pkg::WORD_W-1:0] op_b;
    longint                     sa;
    longint                     sb;
    longint                     quot;
    r = '0;
    r.error = rsc_pkg::ERR_NONE;
    case (kind)
      rsc_pkg::KIND_PUSH: begin
        if (stack_level < STACK_DEPTH) begin
          stack_mem[stack_level] = number;
          stack_level++;
        end else begin
          r.error = rsc_pkg::ERR_OVERFLOW;
        end
      end
      rsc_pkg::KIND_PRINT: begin
        if (stack_level > 0) begin
          stack_level--;
          r.shown       = 1'b1;
          r.shown_value = stack_mem[stack_level];
        end else begin
          r.error = rsc_pkg::ERR_INSUFFICIENT;
        end
      end
      rsc_pkg::KIND_ADD, rsc_pkg::KIND_SUB, rsc_pkg::KIND_MUL, rsc_pkg::KIND_DIV: begin
        if (stack_level < 2) begin
          // A lone B is popped and lost, so the stack ends up empty either way.
          stack_level = 0;
          r.error     = rsc_pkg::ERR_INSUFFICIENT;
        end else begin
          op_b        = stack_mem[stack_level-1];
          op_a        = stack_mem[stack_level-2];
          stack_level = stack_level - 2;
          if (kind == rsc_pkg::KIND_DIV && op_b == '0) begin
            r.error = rsc_pkg::ERR_DIVZERO;
          end else begin
            case (kind)
              rsc_pkg::KIND_ADD: stack_mem[stack_level] = op_a + op_b;
              rsc_pkg::KIND_SUB: stack_mem[stack_level] = op_a - op_b;
              rsc_pkg::KIND_MUL: stack_mem[stack_level] = op_a * op_b;
              default: begin
                // Divide in 64 bits so that the most negative word over -1 wraps.
                sa   = $signed(op_a);
                sb   = $signed(op_b);
                quot = sa / sb;
                stack_mem[stack_level] = quot[rsc_pkg::WORD_W-1:0];
              end
            endcase
            stack_level++;
          end
        end
      end
      default: ;
    endcase
    r.depth = rsc_pkg::DEPTH_W'(stack_level);
    return r;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [rsc_pkg::WORD_W-1:0] want_v,
                                      input logic [rsc_pkg::WORD_W-1:0] got_v);
    if (got_v !== want_v) begin
      fail_count_o++;
      $display("%0t ns: %s wrong, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    calc_result_t want;
    if (!rst_ni) begin
      stack_level       = 0;
      result_q.delete();
      fail_count_o      = 0;
      pending_o         = 0;
      checked_o         = 0;
      shown_count_o     = 0;
      underflow_count_o = 0;
      overflow_count_o  = 0;
      divzero_count_o   = 0;
    end else begin
      if (tok_i.valid && tok_i.ready) begin
        result_q.push_back(eval_token(tok_i.kind, tok_i.number));
      end
      if (res_i.valid && res_i.ready) begin
        if (result_q.size() == 0) begin
          fail_count_o++;
          $display({"%0t ns: result word with nothing expected, ",
                    "actual shown %0b value %0h error %0d depth %0d"},
                   $time, res_i.shown, res_i.shown_value, res_i.error, res_i.depth);
        end else begin
          want = result_q.pop_front();
          checked_o++;
          if (want.shown) shown_count_o++;
          case (want.error)
            rsc_pkg::ERR_INSUFFICIENT: underflow_count_o++;
            rsc_pkg::ERR_OVERFLOW:     overflow_count_o++;
            rsc_pkg::ERR_DIVZERO:      divzero_count_o++;
            default: ;
          endcase
          check_field("shown", rsc_pkg::WORD_W'(want.shown),
                      rsc_pkg::WORD_W'(res_i.shown));
          check_field("shown_value", want.shown_value, res_i.shown_value);
          check_field("error", rsc_pkg::WORD_W'(want.error),
                      rsc_pkg::WORD_W'(res_i.error));
          check_field("depth", rsc_pkg::WORD_W'(want.depth),
                      rsc_pkg::WORD_W'(res_i.depth));
        end
      end
      pending_o = result_q.size();
    end
  end

endmodule

// File: tb/sv/rpn_stack_calculator_core_tb.sv
`timescale 1ns / 1ps

module rpn_stack_calculator_core_tb;

  localparam int unsigned STACK_DEPTH  = 32;
  // Kind codes the block must ignore; they have no name in the package.
  localparam logic [rsc_pkg::KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [rsc_pkg::KIND_W-1:0] KIND_SPARE_7 = 3'd7;
  localparam int unsigned TOKEN_TARGET = 1300;
  // The slowest token is a divide; the limit allows for random stalls on both
  // sides.
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rsc_in_if  tok ();
  rsc_out_if res ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned shown_count;
  int unsigned underflow_count;
  int unsigned overflow_count;
  int unsigned divzero_count;

  // Stimulus-side bookkeeping. The level here is only a rough guess of the stack
  // depth used to shape sequences; a divide by zero makes it run one high.
  int unsigned tokens_sent = 0;
  int unsigned level = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  rpn_stack_calculator_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (tok),
    .res_o (res)
  );

  rpn_stack_calculator_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) calc_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tok_i            (tok),
    .res_i            (res),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .shown_count_o    (shown_count),
    .underflow_count_o(underflow_count),
    .overflow_count_o (overflow_count),
    .divzero_count_o  (divzero_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d result words outstanding",
               cycle_count, pending);
      $display("rpn_stack_calculator_core: mismatch");
      $finish;
    end
  end

  // Result side. Ready drops at random about a quarter of the time, never during a
  // quiet stretch, and once for a long hold-off so that the block backs up and has
  // to stall its token input while the sender keeps offering.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      res.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      res.ready <= 1'b0;
    end else begin
      res.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end
  end

  // Numbers lean toward the corners: zero, one, minus one and the two extremes,
  // plus small values so that divisions give varied quotients.
  function automatic logic [rsc_pkg::WORD_W-1:0] pick_number();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return 32'd1;
      5, 6: return rsc_pkg::WORD_W'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [rsc_pkg::KIND_W-1:0] pick_op();
    case ($urandom_range(0, 3))
      0: return rsc_pkg::KIND_ADD;
      1: return rsc_pkg::KIND_SUB;
      2: return rsc_pkg::KIND_MUL;
      default: return rsc_pkg::KIND_DIV;
    endcase
  endfunction

  // Offers one token word and returns at the edge where it is taken. Valid stays
  // high into the next call unless that call opens an idle gap first.
  task automatic send_token(input logic [rsc_pkg::KIND_W-1:0] kind,
                            input logic [rsc_pkg::WORD_W-1:0] number);
    if (!quiet && $urandom_range(0, 99) < 25) begin
      tok.valid  <= 1'b0;
      tok.kind   <= rsc_pkg::KIND_W'($urandom);
      tok.number <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    tok.valid  <= 1'b1;
    tok.kind   <= kind;
    tok.number <= number;
    @(posedge clk_i);
    while (!tok.ready) @(posedge clk_i);
    case (kind)
      rsc_pkg::KIND_PUSH:  if (level < STACK_DEPTH) level++;
      rsc_pkg::KIND_PRINT: if (level > 0) level--;
      rsc_pkg::KIND_ADD, rsc_pkg::KIND_SUB, rsc_pkg::KIND_MUL, rsc_pkg::KIND_DIV:
        level = (level >= 2) ? level - 1 : 0;
      default: ;
    endcase
    // Ignored kinds do not count toward the amount of stimulus.
    if (kind <= rsc_pkg::KIND_PRINT) tokens_sent++;
  endtask

  // A well-formed expression: operators only when two operands are present, then
  // prints until the stack is empty again. Mostly short, now and then long.
  task automatic run_expression();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(3, 16);
    repeat (len) begin
      if (level < 2 || (level < STACK_DEPTH && $urandom_range(0, 99) < 45)) begin
        send_token(rsc_pkg::KIND_PUSH, pick_number());
      end else begin
        send_token(pick_op(), $urandom);
      end
    end
    while (level > 0) send_token(rsc_pkg::KIND_PRINT, $urandom);
  endtask

  // Fills the stack to the top, pushes a few more to hit the overflow case, and
  // then drains it with a mix of operators and prints.
  task automatic run_fill();
    while (level < STACK_DEPTH) send_token(rsc_pkg::KIND_PUSH, pick_number());
    repeat ($urandom_range(1, 3)) send_token(rsc_pkg::KIND_PUSH, pick_number());
    while (level > 0) begin
      send_token(($urandom_range(0, 2) == 0) ? rsc_pkg::KIND_PRINT : pick_op(), $urandom);
    end
  endtask

  // Unstructured tokens of every kind code, including the two unused ones.
  task automatic run_noise();
    logic [rsc_pkg::KIND_W-1:0] kind;
    repeat ($urandom_range(1, 10)) begin
      kind = rsc_pkg::KIND_W'($urandom_range(0, 7));
      send_token(kind, pick_number());
    end
  endtask

  initial begin
    bit          hold_done;
    bit          pause_done;
    int unsigned pick;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    tok.valid  = 1'b0;
    tok.kind   = rsc_pkg::KIND_PUSH;
    tok.number = '0;
    res.ready  = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed tokens: operators and print on an empty stack, an operator with
    // only B present, the ignored codes, wraparound of multiply, the most
    // negative word divided by minus one, truncation toward zero of a negative
    // quotient, and a divide by zero that eats both operands.
    send_token(rsc_pkg::KIND_PRINT, 32'h0000_0000);
    send_token(rsc_pkg::KIND_ADD,   32'hffff_ffff);
    send_token(rsc_pkg::KIND_PUSH,  32'h7fff_ffff);
    send_token(rsc_pkg::KIND_SUB,   32'h0000_0000);
    send_token(KIND_SPARE_6,        32'h8000_0000);
    send_token(rsc_pkg::KIND_PUSH,  32'h8000_0000);
    send_token(rsc_pkg::KIND_PUSH,  32'hffff_ffff);
    send_token(rsc_pkg::KIND_DIV,   32'h0000_0000);
    send_token(rsc_pkg::KIND_PUSH,  32'h7fff_ffff);
    send_token(rsc_pkg::KIND_ADD,   32'h0000_0000);
    send_token(rsc_pkg::KIND_PUSH,  32'h7fff_ffff);
    send_token(rsc_pkg::KIND_MUL,   32'h0000_0000);
    send_token(rsc_pkg::KIND_PUSH,  32'hffff_fff9);
    send_token(rsc_pkg::KIND_PUSH,  32'h0000_0002);
    send_token(rsc_pkg::KIND_DIV,   32'h0000_0000);
    send_token(rsc_pkg::KIND_SUB,   32'h0000_0000);
    send_token(rsc_pkg::KIND_PUSH,  32'h0000_0000);
    send_token(rsc_pkg::KIND_DIV,   32'h0000_0000);
    send_token(rsc_pkg::KIND_PUSH,  32'h0000_0005);
    send_token(rsc_pkg::KIND_PUSH,  32'hffff_fffe);
    send_token(rsc_pkg::KIND_DIV,   32'h0000_0000);
    send_token(KIND_SPARE_7,        32'h7fff_ffff);
    send_token(rsc_pkg::KIND_PRINT, 32'h0000_0000);
    send_token(rsc_pkg::KIND_MUL,   32'h0000_0000);
    level = 0;

    // Random part, built from episodes. Along the way: a long hold-off on the
    // result side, a stretch with no idling on either side, and one pause of the
    // sender until every outstanding result word has come back.
    while (tokens_sent < TOKEN_TARGET) begin
      if (!hold_done && tokens_sent > 400) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && tokens_sent > 900) begin
        pause_done = 1'b1;
        tok.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      quiet = (tokens_sent >= 550 && tokens_sent < 750);
      pick  = $urandom_range(0, 99);
      if (pick < 10) begin
        run_fill();
      end else if (pick < 75) begin
        run_expression();
      end else begin
        run_noise();
      end
    end
    quiet = 1'b0;
    tok.valid <= 1'b0;

    // Let the checker log the last token, wait for the last result word, then give
    // the block time to show any extra one.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d tokens; %0d result words checked, %0d of them printed values.",
             tokens_sent, checked, shown_count);
    $display("Errors met: %0d too few operands, %0d full stack, %0d divide by zero.",
             underflow_count, overflow_count, divzero_count);
    if (fail_count == 0 && pending == 0) begin
      $display("rpn_stack_calculator_core: match");
    end else begin
      $display("rpn_stack_calculator_core: mismatch");
    end
    $finish;
  end

endmodule
